FILE: sv/csss_pkg.sv
// csss_pkg: shared types, constants and functions for the case-insensitive
// substring search block (cells and top level)
// no dependencies
package csss_pkg;

  // pattern and text sizes
  localparam int PATTERN_MAX = 16;
  localparam int INDEX_BITS  = 16;
  localparam int PM_IDX_BITS = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // configuration port geometry
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 2;
  localparam int LEN_BITS      = 5;

  // register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } cfg_reg_t;

  // control broadcast to every cell
  typedef struct packed {
    logic [7:0] text_byte;  // case-folded text byte
    logic       step;       // advance the partial-match bit
    logic       clear;      // end of text, drop partial matches
  } cell_ctl_t;

  // ascii upper case to lower case, everything else unchanged
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[8'h41:8'h5A]}) begin
      r = b + 8'h20;
    end
    return r;
  endfunction

endpackage

FILE: sv/csss_cell.sv
// csss_cell: one position of the shift-and partial-match row
// depends on csss_pkg
module csss_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  csss_pkg::cell_ctl_t  ctl,
  input  logic [7:0]           pat_byte,
  input  logic                 active,
  input  logic                 match_in,
  output logic                 match_out,
  output logic                 match_nxt
);
  import csss_pkg::*;

  logic pm_r;
  logic eq;

  // compare this pattern byte against the text byte
  assign eq        = active && (fold_case(pat_byte) == ctl.text_byte);
  assign match_nxt = match_in && eq;
  assign match_out = pm_r;

  // partial-match bit, handed to the right-hand neighbor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_r <= 1'b0;
    end else if (ctl.clear) begin
      pm_r <= 1'b0;
    end else if (ctl.step) begin
      pm_r <= match_nxt;
    end
  end

endmodule

FILE: sv/case_insensitive_substring_search.sv
// case_insensitive_substring_search: top level, config registers, text index
// and result register around a row of csss_cell; depends on csss_pkg, csss_cell
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_ready  in_text_byte, in_last_byte
//   out      output     out_valid/out_ready out_found, out_match_start
//   cfg      input      cfg_wr_en          cfg_index, cfg_data
//
// one text byte per cycle while in_ready is high; a result leaves in the cycle
// after the beat that causes it, from a single output register
// the cell row compares all pattern bytes in parallel, so no beat waits on another
// in_ready drops only while a result is held and out_ready is low
// synchronous reset clears pattern, text index and partial-match state
module case_insensitive_substring_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_text_byte,
  input  logic                               in_last_byte,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [csss_pkg::INDEX_BITS-1:0]    out_match_start,
  input  logic                               cfg_wr_en,
  input  logic [csss_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [csss_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import csss_pkg::*;

  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;

  logic [CFG_DATA_BITS-1:0] pat_low_r, pat_high_r;
  logic [LEN_BITS-1:0]      pat_len_r;
  logic [INDEX_BITS-1:0]    idx_r, idx_nxt;
  logic                     reported_r, reported_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     found_r, found_nxt;
  logic [INDEX_BITS-1:0]    start_r, start_nxt;

  logic [2*CFG_DATA_BITS-1:0] pat_all;
  logic [LEN_BITS-1:0]      len_act, len_m1;
  logic [PM_IDX_BITS-1:0]   hit_sel;
  logic                     len_zero;
  logic                     accept;
  logic                     hit;
  logic                     emit;
  logic [INDEX_BITS-1:0]    tlen, back, start;
  logic [PATTERN_MAX-1:0]   pm_vec, pm_nxt;
  cell_ctl_t                ctl;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r  <= '0;
      pat_high_r <= '0;
      pat_len_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PAT_LOW:  pat_low_r  <= cfg_data;
        REG_PAT_HIGH: pat_high_r <= cfg_data;
        REG_PAT_LEN:  pat_len_r  <= cfg_data[LEN_BITS-1:0];
        default:      ;
      endcase
    end
  end

  // active length clamped to the row size
  assign len_act  = (pat_len_r > LEN_BITS'(PATTERN_MAX)) ? LEN_BITS'(PATTERN_MAX)
                                                         : pat_len_r;
  assign len_zero = (len_act == '0);
  assign len_m1   = len_act - LEN_BITS'(1);
  assign hit_sel  = len_m1[PM_IDX_BITS-1:0];
  assign pat_all  = {pat_high_r, pat_low_r};

  // handshake
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // broadcast control to the row
  always_comb begin
    ctl.text_byte = fold_case(in_text_byte);
    ctl.step      = accept && !reported_r && !len_zero;
    ctl.clear     = accept && in_last_byte;
  end

  // row of cells, each but the first fed by its left neighbor's partial-match bit
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    logic m_in;
    if (i == 0) begin : g_first
      assign m_in = 1'b1;
    end else begin : g_rest
      assign m_in = pm_vec[i-1];
    end
    csss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .pat_byte  (pat_all[8*i +: 8]),
      .active    (LEN_BITS'(i) < len_act),
      .match_in  (m_in),
      .match_out (pm_vec[i]),
      .match_nxt (pm_nxt[i])
    );
  end

  // match detection and result value
  assign hit   = !len_zero && pm_nxt[hit_sel];
  assign tlen  = (idx_r == IDX_MAX) ? IDX_MAX : idx_r + INDEX_BITS'(1);
  assign back  = INDEX_BITS'(len_m1);
  assign start = (idx_r >= back) ? idx_r - back : '0;
  assign emit  = accept && !reported_r && (hit || in_last_byte);

  // text state next values
  always_comb begin
    idx_nxt      = idx_r;
    reported_nxt = reported_r;
    if (accept) begin
      if (in_last_byte) begin
        idx_nxt      = '0;
        reported_nxt = 1'b0;
      end else begin
        idx_nxt      = tlen;
        reported_nxt = reported_r || hit;
      end
    end
  end

  // output register next values
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    found_nxt     = found_r;
    start_nxt     = start_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      found_nxt     = len_zero || hit;
      start_nxt     = hit ? start : tlen;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      reported_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      reported_r  <= reported_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    start_r <= start_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = found_r;
  assign out_match_start = start_r;

  // a reported text stays silent
  a_no_emit_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && reported_r) |-> !emit)
    else $error("result emitted after text already reported");

  // last beat leaves clean text state
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (idx_r == '0 && !reported_r && pm_vec == '0))
    else $error("text state not cleared after last beat");

  // a match mid-text marks the text as reported
  a_report_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !reported_r && hit && !in_last_byte) |=> reported_r)
    else $error("match not recorded");

  // an emitted result is presented next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted result not presented");

endmodule

FILE: tb/sv/case_insensitive_substring_search_tb.sv
// case_insensitive_substring_search_tb: self-checking bench for the
// case-insensitive substring search top level, with its own shift-and search model
// depends on csss_pkg and case_insensitive_substring_search
module case_insensitive_substring_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import csss_pkg::*;

  localparam int CLK_HALF_NS  = 5;
  localparam int RESET_CYCLES = 5;
  localparam int SETTLE_CYCLES = 4;
  localparam longint LIMIT_NS = 64'd10_000_000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_BEATS   = 80;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last;
  } text_beat_t;

  typedef struct packed {
    logic                  found;
    logic [INDEX_BITS-1:0] start;
  } search_report_t;

  // dut ports
  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               in_text_byte = 8'h00;
  logic                     in_last_byte = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_found;
  logic [INDEX_BITS-1:0]    out_match_start;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // search model state and its copy of the registers
  logic [63:0]           pat_low = '0;
  logic [63:0]           pat_high = '0;
  logic [LEN_BITS-1:0]   pat_len = '0;
  logic [PATTERN_MAX-1:0] partial_bits = '0;
  logic [INDEX_BITS-1:0] text_pos = '0;
  logic                  reported = 1'b0;

  text_beat_t     text_beats_q[$];
  search_report_t match_reports_q[$];
  text_beat_t     beat;
  search_report_t exp_r;

  logic calm = 1'b0;
  int   errors = 0;
  int   beats_pushed = 0;
  int   beats_accepted = 0;
  int   texts_queued = 0;
  int   found_seen = 0;
  int   missed_seen = 0;
  int   settings = 0;

  case_insensitive_substring_search dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_text_byte    (in_text_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_match_start (out_match_start),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // clock
  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // hard stop
  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  // ascii upper to lower, everything else unchanged
  function automatic logic [7:0] lower_ascii(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'h20;
    end
    return b;
  endfunction

  function automatic logic [7:0] pattern_at(input int i);
    if (i < 8) begin
      return pat_low[i*8 +: 8];
    end
    return pat_high[(i-8)*8 +: 8];
  endfunction

  function automatic int active_len();
    return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
  endfunction

  // random case swap on letters only
  function automatic logic [7:0] flip_case(input logic [7:0] b);
    logic letter;
    letter = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    if (letter && $urandom_range(0, 1) == 1) begin
      return b ^ 8'h20;
    end
    return b;
  endfunction

  // small alphabet around the folding boundaries, so matches happen often
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 13))
      0:       return 8'h61;
      1:       return 8'h41;
      2:       return 8'h62;
      3:       return 8'h42;
      4:       return 8'h7A;
      5:       return 8'h5A;
      6:       return 8'h40;
      7:       return 8'h5B;
      8:       return 8'h60;
      9:       return 8'h7B;
      10:      return 8'hC1;
      11:      return 8'hE1;
      12:      return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic take_gap();
    return !calm && ($urandom_range(0, 99) < 9);
  endfunction

  // one accepted text byte through the shift-and search
  function automatic void search_step(input logic [7:0] raw, input logic last);
    logic [7:0]            b;
    logic [PATTERN_MAX-1:0] eq;
    logic [INDEX_BITS-1:0] tlen;
    logic [INDEX_BITS-1:0] back;
    int                    len;
    b    = lower_ascii(raw);
    len  = active_len();
    tlen = (text_pos != '1) ? text_pos + 1'b1 : text_pos;
    if (!reported) begin
      if (len == 0) begin
        if (last) begin
          match_reports_q.push_back('{found: 1'b1, start: tlen});
        end
      end else begin
        eq = '0;
        for (int i = 0; i < len; i++) begin
          if (lower_ascii(pattern_at(i)) == b) begin
            eq[i] = 1'b1;
          end
        end
        partial_bits = ((partial_bits << 1) | 1'b1) & eq;
        if (partial_bits[len-1]) begin
          back = INDEX_BITS'(len - 1);
          match_reports_q.push_back('{found: 1'b1,
                                      start: (text_pos >= back) ? text_pos - back : '0});
          reported = 1'b1;
        end else if (last) begin
          match_reports_q.push_back('{found: 1'b0, start: tlen});
        end
      end
    end
    if (last) begin
      partial_bits = '0;
      text_pos     = '0;
      reported     = 1'b0;
    end else begin
      text_pos = tlen;
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        search_step(in_text_byte, in_last_byte);
        beats_accepted++;
      end
      if (in_valid && !in_ready) begin
        // hold the beat until taken
      end else if (text_beats_q.size() != 0 && !take_gap()) begin
        beat = text_beats_q.pop_front();
        in_text_byte <= beat.text_byte;
        in_last_byte <= beat.last;
        in_valid     <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (match_reports_q.size() == 0) begin
          $display("%0t: unexpected result found=%0b match_start=%0d",
                   $time, out_found, out_match_start);
          errors++;
        end else begin
          exp_r = match_reports_q.pop_front();
          if (out_found !== exp_r.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b",
                     $time, exp_r.found, out_found);
            errors++;
          end
          if (out_match_start !== exp_r.start) begin
            $display("%0t: match_start mismatch, expected %0d, actual %0d",
                     $time, exp_r.start, out_match_start);
            errors++;
          end
          if (exp_r.found) begin
            found_seen++;
          end else begin
            missed_seen++;
          end
        end
      end
      out_ready <= !take_gap();
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic last);
    text_beats_q.push_back('{text_byte: b, last: last});
    beats_pushed++;
    if (last) begin
      texts_queued++;
    end
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_beat(s[i], i == s.len() - 1);
    end
  endtask

  // register write, mirrored into the model
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PAT_LOW:  pat_low  = data;
      REG_PAT_HIGH: pat_high = data;
      REG_PAT_LEN:  pat_len  = data[LEN_BITS-1:0];
      default: ;
    endcase
  endtask

  // full pattern load, plus a write to the unused index that must be ignored
  task automatic load_pattern(input logic [127:0] bytes, input logic [LEN_BITS-1:0] len);
    logic [63:0] len_word;
    len_word = {$urandom, $urandom};
    len_word[LEN_BITS-1:0] = len;
    write_reg(REG_PAT_LOW, bytes[63:0]);
    write_reg(REG_PAT_HIGH, bytes[127:64]);
    write_reg(REG_PAT_LEN, len_word);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    settings++;
  endtask

  // wait until every beat is taken and every result is back, then settle
  task automatic drain();
    while (beats_accepted != beats_pushed || match_reports_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly texts that carry the pattern in mixed case, some cut short, some noise
  task automatic queue_random_texts(input int budget);
    logic [7:0] txt[$];
    int plen;
    int kind;
    int n;
    int sent;
    sent = 0;
    plen = active_len();
    while (sent < budget) begin
      txt.delete();
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        n = $urandom_range(1, 12);
        repeat (n) txt.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 6)) txt.push_back(pick_char());
        n = (kind < 7) ? plen : $urandom_range(0, plen);
        for (int i = 0; i < n; i++) begin
          txt.push_back(flip_case(pattern_at(i)));
        end
        repeat ($urandom_range(0, 6)) txt.push_back(pick_char());
      end
      if (txt.size() == 0) begin
        txt.push_back(pick_char());
      end
      foreach (txt[i]) begin
        push_beat(txt[i], i == txt.size() - 1);
      end
      sent += txt.size();
    end
  endtask

  // stimulus sequence
  initial begin
    logic [127:0]        pat_bytes;
    logic [LEN_BITS-1:0] raw_len;
    int                  r;
    int                  plen;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // upper-case pattern: first byte must fold too
    load_pattern(128'h434241, 5'd3);
    queue_text("xAbCzz");
    queue_text("abc");
    queue_text("aB[");
    push_beat(8'hFF, 1'b1);
    drain();

    // empty pattern reports found at the text length
    load_pattern({$urandom, $urandom, $urandom, $urandom}, 5'd0);
    push_beat(8'h80, 1'b0);
    push_beat(8'h00, 1'b1);
    drain();

    // length above the maximum, full-width pattern matched at the last byte
    pat_bytes = 128'h51FE014E6D7F7B605B40C180615AFF00;
    load_pattern(pat_bytes, 5'd31);
    for (int i = 0; i < 16; i++) begin
      push_beat(flip_case(pat_bytes[i*8 +: 8]), i == 15);
    end
    drain();

    // random phases, each with a fresh pattern
    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0:       raw_len = 5'd1;
        1:       raw_len = 5'd16;
        2:       raw_len = 5'd0;
        3:       raw_len = 5'd31;
        4, 5:    raw_len = 5'd16;
        default: begin
          r = $urandom_range(0, 19);
          raw_len = (r <= 16) ? LEN_BITS'(r) : LEN_BITS'($urandom_range(17, 31));
        end
      endcase
      plen = (raw_len > PATTERN_MAX) ? PATTERN_MAX : int'(raw_len);
      for (int i = 0; i < 16; i++) begin
        if (i >= plen) begin
          pat_bytes[i*8 +: 8] = 8'($urandom);
        end else if (k == 4) begin
          pat_bytes[i*8 +: 8] = 8'hFF;
        end else if (k == 5) begin
          pat_bytes[i*8 +: 8] = 8'h00;
        end else begin
          pat_bytes[i*8 +: 8] = pick_char();
        end
      end
      load_pattern(pat_bytes, raw_len);
      calm = (k == 6 || k == 7);
      queue_random_texts(PHASE_BEATS);
      drain();
    end
    calm = 1'b0;

    $display("run covered %0d texts in %0d beats over %0d pattern settings",
             texts_queued, beats_accepted, settings);
    $display("%0d texts matched, %0d ended without a match, %0d errors",
             found_seen, missed_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/csss_pkg.sv
sv/csss_cell.sv
sv/case_insensitive_substring_search.sv
tb/sv/case_insensitive_substring_search_tb.sv
